FILE: rtl/core/aavr_pkg.sv
// Package: shared widths, types and the CORDIC angle table for the axis-angle rotator.
`timescale 1ns / 1ps
package aavr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam int VW  = 32;   // vector component, Q16.16
    localparam int AW  = 18;   // axis component, Q2.16
    localparam int ANW = 16;   // turn angle
    localparam int CW  = 19;   // cosine / sine, Q.16
    localparam int XW  = 34;   // CORDIC x / y, Q2.30 with headroom
    localparam int ZW  = 33;   // CORDIC residual angle, 2^-32 turn
    localparam int MW  = 58;   // matrix term before rounding, Q.48
    localparam int TW  = 25;   // matrix term after rounding, Q.16
    localparam int PW  = 57;   // term times vector component, Q.32
    localparam int SW  = 59;   // row sum, Q.32

    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

    typedef logic [2:0][VW-1:0] t_vec3;

    typedef struct packed {
        t_vec3              vec;
        logic [2:0][AW-1:0] axis;
    } t_side;

    typedef logic [8:0][TW-1:0] t_mat;

    // atan(2^-idx) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/aavr_cordic.sv
// Pipelined rotation-mode CORDIC: one iteration per stage, cosine and sine out.
`timescale 1ns / 1ps
module aavr_cordic #(
    parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [aavr_pkg::ANW-1:0]    i_angle,
    input  aavr_pkg::t_side             i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [aavr_pkg::CW-1:0] o_c,
    output logic signed [aavr_pkg::CW-1:0] o_s,
    output aavr_pkg::t_side             o_side
);
    localparam int NS = (CORDIC_STEPS < aavr_pkg::ATAN_ENTRIES) ?
                        CORDIC_STEPS : aavr_pkg::ATAN_ENTRIES;
    localparam int L  = NS + 2;
    localparam int XW = aavr_pkg::XW;
    localparam int ZW = aavr_pkg::ZW;
    localparam int CW = aavr_pkg::CW;

    logic [L-1:0] r_v;
    logic [L:0]   w_rdy;

    logic signed [XW-1:0] r_x [0:NS];
    logic signed [XW-1:0] r_y [0:NS];
    logic signed [ZW-1:0] r_z [0:NS];
    logic [NS:0]          r_flip;
    aavr_pkg::t_side      r_side [0:NS+1];
    logic signed [CW-1:0] r_c;
    logic signed [CW-1:0] r_s;

    logic                 n_flip;
    logic [31:0]          n_t;
    logic signed [XW-1:0] n_xf;
    logic signed [XW-1:0] n_yf;
    logic signed [XW-1:0] n_xr;
    logic signed [XW-1:0] n_yr;

    always_comb begin
        w_rdy[L] = i_ready;
        for (int k = L - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < L; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // fold the second and third quarter turn onto the first and fourth
    always_comb begin
        n_flip = i_angle[15] ^ i_angle[14];
        n_t    = {i_angle, 16'h0000} - (n_flip ? 32'h80000000 : 32'h00000000);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_x[0]    <= XW'($signed({1'b0, aavr_pkg::CORDIC_GAIN}));
            r_y[0]    <= '0;
            r_z[0]    <= ZW'($signed(n_t));
            r_flip[0] <= n_flip;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = ZW'($signed({1'b0, aavr_pkg::atan_turn(k)}));
        always_ff @(posedge i_clk) begin
            if (w_rdy[k+1]) begin
                r_flip[k+1] <= r_flip[k];
                r_side[k+1] <= r_side[k];
                if (!r_z[k][ZW-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATAN;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATAN;
                end
            end
        end
    end

    // undo the fold, round Q2.30 to Q.16
    always_comb begin
        n_xf = r_flip[NS] ? -r_x[NS] : r_x[NS];
        n_yf = r_flip[NS] ? -r_y[NS] : r_y[NS];
        n_xr = n_xf + XW'(8192);
        n_yr = n_yf + XW'(8192);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS+1]) begin
            r_c          <= $signed(n_xr[14+CW-1:14]);
            r_s          <= $signed(n_yr[14+CW-1:14]);
            r_side[NS+1] <= r_side[NS];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[L-1];
    assign o_c     = r_c;
    assign o_s     = r_s;
    assign o_side  = r_side[NS+1];

endmodule

FILE: rtl/core/aavr_matrix.sv
// Three-stage builder of the nine axis-angle rotation matrix terms.
`timescale 1ns / 1ps
module aavr_matrix (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [aavr_pkg::CW-1:0] i_c,
    input  logic signed [aavr_pkg::CW-1:0] i_s,
    input  aavr_pkg::t_side                i_side,
    output logic                           o_valid,
    input  logic                           i_ready,
    output aavr_pkg::t_mat                 o_m,
    output aavr_pkg::t_vec3                o_vec
);
    localparam int L  = 3;
    localparam int MW = aavr_pkg::MW;
    localparam int TW = aavr_pkg::TW;
    localparam int AW = aavr_pkg::AW;
    localparam int CW = aavr_pkg::CW;

    logic [L-1:0] r_v;
    logic [L:0]   w_rdy;

    // stage 0: axis products
    logic signed [2*AW-1:0]  r_sq [0:2];
    logic signed [2*AW-1:0]  r_p  [0:2];   // xy, xz, yz
    logic signed [AW+CW-1:0] r_ks [0:2];
    logic signed [CW:0]      r_omc;
    logic signed [CW-1:0]    r_c0;
    aavr_pkg::t_vec3         r_vec0;
    // stage 1: full-precision terms
    logic signed [MW-1:0]    r_d [0:2];
    logic signed [MW-1:0]    r_o [0:2];
    logic signed [MW-1:0]    r_w [0:2];
    aavr_pkg::t_vec3         r_vec1;
    // stage 2: rounded terms
    aavr_pkg::t_mat          r_m;
    aavr_pkg::t_vec3         r_vec2;

    logic signed [AW-1:0]    w_a [0:2];
    logic signed [MW-1:0]    n_sum [0:8];

    always_comb begin
        w_rdy[L] = i_ready;
        for (int k = L - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < L; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = $signed(i_side.axis[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*AW)'(w_a[i]) * (2*AW)'(w_a[i]);
                r_ks[i] <= (AW+CW)'(w_a[i]) * (AW+CW)'(i_s);
            end
            r_p[0] <= (2*AW)'(w_a[0]) * (2*AW)'(w_a[1]);
            r_p[1] <= (2*AW)'(w_a[0]) * (2*AW)'(w_a[2]);
            r_p[2] <= (2*AW)'(w_a[1]) * (2*AW)'(w_a[2]);
            r_omc  <= (CW+1)'(65536) - (CW+1)'(i_c);
            r_c0   <= i_c;
            r_vec0 <= i_side.vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= (MW'(r_sq[i]) <<< 16)
                        + (MW'(64'sh1_0000_0000) - MW'(r_sq[i])) * MW'(r_c0);
                r_o[i] <= MW'(r_omc) * MW'(r_p[i]);
                r_w[i] <= MW'(r_ks[i]) <<< 16;
            end
            r_vec1 <= r_vec0;
        end
    end

    // row-major: xx xy xz / yx yy yz / zx zy zz
    always_comb begin
        n_sum[0] = r_d[0];
        n_sum[1] = r_o[0] - r_w[2];
        n_sum[2] = r_o[1] + r_w[1];
        n_sum[3] = r_o[0] + r_w[2];
        n_sum[4] = r_d[1];
        n_sum[5] = r_o[2] - r_w[0];
        n_sum[6] = r_o[1] - r_w[1];
        n_sum[7] = r_o[2] + r_w[0];
        n_sum[8] = r_d[2];
        for (int j = 0; j < 9; j++) begin
            n_sum[j] = n_sum[j] + MW'(64'sh8000_0000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int j = 0; j < 9; j++) begin
                r_m[j] <= n_sum[j][32+TW-1:32];
            end
            r_vec2 <= r_vec1;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[L-1];
    assign o_m     = r_m;
    assign o_vec   = r_vec2;

endmodule

FILE: rtl/core/aavr_rows.sv
// Three-stage matrix-vector product with rounding and saturation per row.
`timescale 1ns / 1ps
module aavr_rows (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  aavr_pkg::t_mat  i_m,
    input  aavr_pkg::t_vec3 i_vec,
    output logic            o_valid,
    input  logic            i_ready,
    output aavr_pkg::t_vec3 o_rot
);
    localparam int L  = 3;
    localparam int PW = aavr_pkg::PW;
    localparam int SW = aavr_pkg::SW;
    localparam int VW = aavr_pkg::VW;

    logic [L-1:0] r_v;
    logic [L:0]   w_rdy;

    logic signed [PW-1:0] r_prod [0:8];
    logic signed [SW-1:0] r_sum  [0:2];
    aavr_pkg::t_vec3      r_rot;

    always_comb begin
        w_rdy[L] = i_ready;
        for (int k = L - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < L; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[3*r+j] <= PW'($signed(i_m[3*r+j])) * PW'($signed(i_vec[j]));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int r = 0; r < 3; r++) begin
                r_sum[r] <= SW'(r_prod[3*r]) + SW'(r_prod[3*r+1]) + SW'(r_prod[3*r+2])
                          + SW'(32768);
            end
        end
    end

    // keep bits [47:16]; clamp when the upper bits are not all sign
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int r = 0; r < 3; r++) begin
                if (r_sum[r][SW-1:16+VW-1] == '0 || r_sum[r][SW-1:16+VW-1] == '1) begin
                    r_rot[r] <= r_sum[r][16+VW-1:16];
                end else if (r_sum[r][SW-1]) begin
                    r_rot[r] <= {1'b1, {(VW-1){1'b0}}};
                end else begin
                    r_rot[r] <= {1'b0, {(VW-1){1'b1}}};
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[L-1];
    assign o_rot   = r_rot;

endmodule

FILE: rtl/core/axis_angle_vector_rotate_top.sv
// Throughput: one item per cycle; every stage of the CORDIC, matrix and row pipes
// holds one item and moves it on when the stage after it is free.
// A stalled output back-fills empty stages, so the input keeps accepting until full.
// Reset: synchronous, active low; clears all stage valid bits, data is not reset.
`timescale 1ns / 1ps
module axis_angle_vector_rotate_top #(
    parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle, 2 pad bits
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [95:0]  m_axis_tdata
);
    aavr_pkg::t_side                w_side_in;
    aavr_pkg::t_side                w_side_cs;
    logic                           w_cs_valid;
    logic                           w_cs_ready;
    logic signed [aavr_pkg::CW-1:0] w_c;
    logic signed [aavr_pkg::CW-1:0] w_s;
    logic                           w_m_valid;
    logic                           w_m_ready;
    aavr_pkg::t_mat                 w_m;
    aavr_pkg::t_vec3                w_vec;
    aavr_pkg::t_vec3                w_rot;

    always_comb begin
        w_side_in.vec[0]  = s_axis_tdata[31:0];
        w_side_in.vec[1]  = s_axis_tdata[63:32];
        w_side_in.vec[2]  = s_axis_tdata[95:64];
        w_side_in.axis[0] = s_axis_tdata[113:96];
        w_side_in.axis[1] = s_axis_tdata[131:114];
        w_side_in.axis[2] = s_axis_tdata[149:132];
    end

    aavr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_angle (s_axis_tdata[165:150]),
        .i_side  (w_side_in),
        .o_valid (w_cs_valid),
        .i_ready (w_cs_ready),
        .o_c     (w_c),
        .o_s     (w_s),
        .o_side  (w_side_cs)
    );

    aavr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cs_valid),
        .o_ready (w_cs_ready),
        .i_c     (w_c),
        .i_s     (w_s),
        .i_side  (w_side_cs),
        .o_valid (w_m_valid),
        .i_ready (w_m_ready),
        .o_m     (w_m),
        .o_vec   (w_vec)
    );

    aavr_rows u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_valid),
        .o_ready (w_m_ready),
        .i_m     (w_m),
        .i_vec   (w_vec),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rot   (w_rot)
    );

    assign m_axis_tdata = w_rot;

endmodule

FILE: verif/axis_angle_vector_rotate_checker.sv
// Checker: predicts the rotated vector for each accepted item and compares the outputs.
`timescale 1ns / 1ps
module axis_angle_vector_rotate_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [167:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [95:0]  i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    localparam int STEPS = aavr_pkg::CORDIC_STEPS_DEF;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_rot;

    t_rot rot_q[$];
    int   fails;

    assign o_fail_count = fails;
    assign o_pending    = rot_q.size();

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // cosine and sine in Q.16 from a fixed-length CORDIC on a folded angle
    function automatic void trig(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] t;
        longint x, y, z, dx, dy;
        logic flip;
        flip = (ang[15:14] == 2'd1) || (ang[15:14] == 2'd2);
        t = {ang, 16'h0};
        if (flip) t = t - 32'h80000000;
        z = longint'($signed(t));
        x = longint'(aavr_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < STEPS && i < aavr_pkg::ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(aavr_pkg::atan_turn(i));
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(aavr_pkg::atan_turn(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = rnd_shift(x, 14);
        s = rnd_shift(y, 14);
    endfunction

    function automatic longint diag(longint a, longint c);
        longint sq;
        sq = a * a;
        return rnd_shift(sq * 65536 + (64'sd4294967296 - sq) * c, 32);
    endfunction

    function automatic longint offd(longint omc, longint ai, longint aj, longint ak,
                                    longint s, bit plus);
        longint v, w;
        v = omc * ai * aj;
        w = ak * s * 65536;
        return rnd_shift(plus ? v + w : v - w, 32);
    endfunction

    function automatic logic [31:0] row(longint m0, longint m1, longint m2,
                                        longint vx, longint vy, longint vz);
        longint r;
        r = rnd_shift(m0 * vx + m1 * vy + m2 * vz, 16);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_rot rotate(logic [167:0] d);
        longint vx, vy, vz, ax, ay, az, c, s, omc;
        t_rot r;
        vx = longint'($signed(d[31:0]));
        vy = longint'($signed(d[63:32]));
        vz = longint'($signed(d[95:64]));
        ax = longint'($signed(d[113:96]));
        ay = longint'($signed(d[131:114]));
        az = longint'($signed(d[149:132]));
        trig(d[165:150], c, s);
        omc = 65536 - c;
        r.x = row(diag(ax, c), offd(omc, ax, ay, az, s, 0), offd(omc, ax, az, ay, s, 1),
                  vx, vy, vz);
        r.y = row(offd(omc, ax, ay, az, s, 1), diag(ay, c), offd(omc, ay, az, ax, s, 0),
                  vx, vy, vz);
        r.z = row(offd(omc, ax, az, ay, s, 0), offd(omc, ay, az, ax, s, 1), diag(az, c),
                  vx, vy, vz);
        return r;
    endfunction

    initial fails = 0;

    always @(posedge i_clk) begin
        t_rot e;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) rot_q.push_back(rotate(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (rot_q.size() == 0) begin
                    $error("unexpected output item %h", i_out_data);
                    fails++;
                end else begin
                    e = rot_q.pop_front();
                    if (i_out_data[31:0] !== e.x) begin
                        $error("rot_x expected %0d actual %0d", e.x, $signed(i_out_data[31:0]));
                        fails++;
                    end
                    if (i_out_data[63:32] !== e.y) begin
                        $error("rot_y expected %0d actual %0d", e.y, $signed(i_out_data[63:32]));
                        fails++;
                    end
                    if (i_out_data[95:64] !== e.z) begin
                        $error("rot_z expected %0d actual %0d", e.z, $signed(i_out_data[95:64]));
                        fails++;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/axis_angle_vector_rotate_top_tb.sv
// Testbench top: drives vectors, axes and angles into the rotator and reports the verdict.
`timescale 1ns / 1ps
module axis_angle_vector_rotate_top_tb;
    localparam int LATENCY = aavr_pkg::CORDIC_STEPS_DEF + 8;
    localparam int AXIS_ONE = 65536;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    int           fail_count;
    int           pending;
    bit           steady;

    axis_angle_vector_rotate_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    axis_angle_vector_rotate_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // stall the output side at random, except in the steady stretch
    always @(posedge i_clk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
    end

    function automatic logic [17:0] rand_axis();
        case ($urandom_range(3))
            0:       return 18'($urandom);
            1:       return 18'($signed(AXIS_ONE - 2 * $urandom_range(AXIS_ONE)));
            default: return 18'($signed($urandom_range(92682) - 46341));
        endcase
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(32'h00FFFFFF)) - 32'sh007FFFFF);
            2:       return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(32'h0FFFFFFF)) - 32'sh07FFFFFF);
        endcase
    endfunction

    // hold the item until accepted, with a random gap before it
    task automatic send_item(input logic [31:0] vx, vy, vz, input logic [17:0] ax, ay, az,
                             input logic [15:0] ang);
        while (!steady && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ang, az, ay, ax, vz, vy, vx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] angs[8];
        int wait_cycles;
        angs = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // quadrant edges with unit axes, extreme fields, non-unit axes
        foreach (angs[i])
            send_item(32'h00010000, 32'h00020000, 32'hFFFD0000, 18'(AXIS_ONE), 18'd0, 18'd0,
                      angs[i]);
        send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                  16'h2000);
        send_item(32'h80000000, 32'h80000000, 32'h80000000, 18'h20000, 18'h20000, 18'h20000,
                  16'hA000);
        send_item(32'h80000000, 32'h7FFFFFFF, 32'h0, 18'h20000, 18'h1FFFF, 18'h0, 16'h5555);
        send_item(32'h0, 32'h0, 32'h0, 18'h0, 18'h0, 18'h0, 16'h1234);
        send_item(32'hFFFFFFFF, 32'h1, 32'h7FFFFFFF, 18'h3FFFF, 18'h1, 18'h0, 16'h8000);
        send_item(32'h00010000, 32'h0, 32'h0, 18'd0, 18'd0, 18'(AXIS_ONE), 16'h4000);
        send_item(32'h00010000, 32'h0, 32'h0, 18'd0, 18'(AXIS_ONE), 18'd0, 16'hC000);
        send_item(32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F, 18'h2AAAA, 18'h15555, 18'h3C3C3,
                  16'hAAAA);

        for (int n = 0; n < 800; n++) begin
            steady = (n >= 300 && n < 420);
            send_item(rand_comp(), rand_comp(), rand_comp(), rand_axis(), rand_axis(),
                      rand_axis(), 16'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
